>>> hdl/slipd_pkg.sv
// ----------------------------------------------------------------------------
// slipd_pkg
// Shared constants and types for the SLIP frame decoder.
// ----------------------------------------------------------------------------
package slipd_pkg;

  // SLIP special bytes: frame end, frame escape and the two escaped codes
  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STAT_W  = 32;

  // Frame length limit after reset
  localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 16'd256;

  // Parser state
  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_RECV = 2'd1,
    ST_ESC  = 2'd2
  } parse_state_t;

endpackage

>>> hdl/slip_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder_unit
// SLIP receive decoder: one raw byte per request in, one status result out.
// ----------------------------------------------------------------------------
// The result is registered and appears the cycle after the request is accepted.
// Throughput: 1 byte per cycle while results drain; parser state, byte count
//   and counters update on accept and the result register frees as it drains.
// Reset (synchronous, rst high): parser awaits start, counts clear,
//   max_length returns to 256, no result is pending.
module slip_frame_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [slipd_pkg::COUNT_W-1:0]        cfg_wr_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [slipd_pkg::BYTE_W-1:0]         rx_byte,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 byte_valid,
  output logic [slipd_pkg::BYTE_W-1:0]         byte_value,
  output logic [slipd_pkg::COUNT_W-1:0]        byte_index,
  output logic                                 frame_done,
  output logic [slipd_pkg::COUNT_W-1:0]        frame_length,
  output logic                                 frame_error,
  output logic [slipd_pkg::STAT_W-1:0]         errors_seen,
  output logic [slipd_pkg::STAT_W-1:0]         frames_seen
);

  logic [slipd_pkg::COUNT_W-1:0] max_length;
  slipd_pkg::parse_state_t       parse_state, parse_state_next;
  logic [slipd_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [slipd_pkg::STAT_W-1:0]  error_count, error_count_next;
  logic [slipd_pkg::STAT_W-1:0]  success_count, success_count_next;

  logic                          valid_c, done_c, err_c;
  logic [slipd_pkg::BYTE_W-1:0]  value_c;
  logic [slipd_pkg::COUNT_W-1:0] index_c, length_c;
  slipd_pkg::parse_state_t       st_c;
  logic [slipd_pkg::COUNT_W-1:0] cnt_c;
  logic                          in_fire;

  // result register drains or is empty
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= slipd_pkg::MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  // Parser: length check first, then the byte in the (possibly reset) state
  always_comb begin
    st_c     = parse_state;
    cnt_c    = byte_count;
    err_c    = 1'b0;
    valid_c  = 1'b0;
    value_c  = '0;
    index_c  = '0;
    done_c   = 1'b0;
    length_c = '0;

    // limit reached: abort the frame, reparse as awaiting start
    if (byte_count >= max_length) begin
      st_c  = slipd_pkg::ST_WAIT;
      cnt_c = '0;
      err_c = 1'b1;
    end

    parse_state_next = st_c;
    byte_count_next  = cnt_c;

    case (st_c)
      slipd_pkg::ST_WAIT: begin
        if (rx_byte == slipd_pkg::FEND) begin
          parse_state_next = slipd_pkg::ST_RECV;
          byte_count_next  = '0;
        end
      end
      slipd_pkg::ST_RECV: begin
        if (rx_byte == slipd_pkg::FESC) begin
          parse_state_next = slipd_pkg::ST_ESC;
        end else if (rx_byte == slipd_pkg::FEND) begin
          // empty frame keeps receiving
          if (cnt_c != '0) begin
            parse_state_next = slipd_pkg::ST_WAIT;
            done_c           = 1'b1;
            length_c         = cnt_c;
          end
        end else begin
          valid_c         = 1'b1;
          value_c         = rx_byte;
          index_c         = cnt_c;
          byte_count_next = cnt_c + slipd_pkg::COUNT_W'(1);
        end
      end
      slipd_pkg::ST_ESC: begin
        if (rx_byte == slipd_pkg::TFEND || rx_byte == slipd_pkg::TFESC) begin
          valid_c          = 1'b1;
          value_c          = (rx_byte == slipd_pkg::TFEND) ?
                             slipd_pkg::FEND : slipd_pkg::FESC;
          index_c          = cnt_c;
          byte_count_next  = cnt_c + slipd_pkg::COUNT_W'(1);
          parse_state_next = slipd_pkg::ST_RECV;
        end else begin
          // bad escape: drop byte, back to awaiting start
          parse_state_next = slipd_pkg::ST_WAIT;
          err_c            = 1'b1;
        end
      end
      default: begin
        parse_state_next = slipd_pkg::ST_WAIT;
        err_c            = 1'b1;
      end
    endcase

    // at most one error per byte
    error_count_next   = error_count + {{(slipd_pkg::STAT_W-1){1'b0}}, err_c};
    success_count_next = success_count + {{(slipd_pkg::STAT_W-1){1'b0}}, done_c};
  end

  // Parser state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= slipd_pkg::ST_WAIT;
      byte_count    <= '0;
      error_count   <= '0;
      success_count <= '0;
    end else if (in_fire) begin
      parse_state   <= parse_state_next;
      byte_count    <= byte_count_next;
      error_count   <= error_count_next;
      success_count <= success_count_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_valid   <= valid_c;
      byte_value   <= value_c;
      byte_index   <= index_c;
      frame_done   <= done_c;
      frame_length <= length_c;
      frame_error  <= err_c;
      errors_seen  <= error_count_next;
      frames_seen  <= success_count_next;
    end
  end

endmodule

>>> hdl/slipd_checker.sv
// ----------------------------------------------------------------------------
// slipd_checker
// Port-level checks for the SLIP frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module slipd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             byte_valid,
  input logic [slipd_pkg::BYTE_W-1:0]     byte_value,
  input logic [slipd_pkg::COUNT_W-1:0]    byte_index,
  input logic                             frame_done,
  input logic [slipd_pkg::COUNT_W-1:0]    frame_length,
  input logic [slipd_pkg::STAT_W-1:0]     errors_seen
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // stalled result keeps its counter value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(errors_seen))
    else $error("stalled result changed");

  // a byte cannot both carry data and close a frame
  a_data_xor_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(byte_valid && frame_done))
    else $error("data byte and frame end together");

  // a closed frame is never empty; idle length reads zero
  a_done_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_done == (frame_length != '0)))
    else $error("frame length disagrees with frame end");

  // no data byte means zeroed byte fields
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> byte_value == '0 && byte_index == '0)
    else $error("byte fields set without a data byte");

endmodule

bind slip_frame_decoder_unit slipd_checker u_slipd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .byte_valid   (byte_valid),
  .byte_value   (byte_value),
  .byte_index   (byte_index),
  .frame_done   (frame_done),
  .frame_length (frame_length),
  .errors_seen  (errors_seen)
);

>>> sim/slip_frame_checker.sv
// ----------------------------------------------------------------------------
// slip_frame_checker
// Watches the request and result channels of the SLIP decoder, predicts the
// status of every accepted byte and compares each result in arrival order.
// ----------------------------------------------------------------------------
module slip_frame_checker
  import slipd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [COUNT_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                byte_valid,
  input  logic [BYTE_W-1:0]   byte_value,
  input  logic [COUNT_W-1:0]  byte_index,
  input  logic                frame_done,
  input  logic [COUNT_W-1:0]  frame_length,
  input  logic                frame_error,
  input  logic [STAT_W-1:0]   errors_seen,
  input  logic [STAT_W-1:0]   frames_seen,
  output int                  fail_count,
  output int                  queued,
  output int                  checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               byte_ok;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] index;
    logic               done;
    logic [COUNT_W-1:0] length;
    logic               err;
    logic [STAT_W-1:0]  errs;
    logic [STAT_W-1:0]  frames;
  } slip_status_t;

  // decoder state as predicted
  parse_state_t       mdl_state;
  logic [COUNT_W-1:0] run_len;
  logic [COUNT_W-1:0] len_limit;
  logic [STAT_W-1:0]  err_total;
  logic [STAT_W-1:0]  frame_total;

  slip_status_t status_q[$];
  slip_status_t want;

  initial begin
    fail_count = 0;
    queued     = 0;
    checked    = 0;
  end

  // one printed line per mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
             $realtime, what, got, exp_val, checked);
    fail_count++;
  endtask

  task automatic cmp(input string what, input logic [31:0] got,
                     input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // status of one received byte; advances the predicted state
  function automatic slip_status_t slip_decode(input logic [BYTE_W-1:0] b);
    slip_status_t r;
    r = '{default: '0};
    // frame at the length limit: abort, then handle byte as in idle
    if (run_len >= len_limit) begin
      mdl_state = ST_WAIT;
      run_len   = '0;
      err_total = err_total + STAT_W'(1);
      r.err     = 1'b1;
    end
    case (mdl_state)
      ST_WAIT: begin
        if (b == FEND) begin
          mdl_state = ST_RECV;
          run_len   = '0;
        end
      end
      ST_RECV: begin
        if (b == FESC) begin
          mdl_state = ST_ESC;
        end else if (b == FEND) begin
          // empty frames keep receiving
          if (run_len != '0) begin
            mdl_state   = ST_WAIT;
            frame_total = frame_total + STAT_W'(1);
            r.done      = 1'b1;
            r.length    = run_len;
          end
        end else begin
          r.byte_ok = 1'b1;
          r.value   = b;
          r.index   = run_len;
          run_len   = run_len + COUNT_W'(1);
        end
      end
      ST_ESC: begin
        if (b == TFEND || b == TFESC) begin
          r.byte_ok = 1'b1;
          r.value   = (b == TFEND) ? FEND : FESC;
          r.index   = run_len;
          run_len   = run_len + COUNT_W'(1);
          mdl_state = ST_RECV;
        end else begin
          // bad escape: byte dropped, back to idle
          mdl_state = ST_WAIT;
          err_total = err_total + STAT_W'(1);
          r.err     = 1'b1;
        end
      end
      default: begin
        mdl_state = ST_WAIT;
        err_total = err_total + STAT_W'(1);
        r.err     = 1'b1;
      end
    endcase
    r.errs   = err_total;
    r.frames = frame_total;
    return r;
  endfunction

  // results drain first: a result never belongs to a same-edge request
  always @(posedge clk) begin
    if (rst) begin
      mdl_state   = ST_WAIT;
      run_len     = '0;
      len_limit   = MAX_LENGTH_RESET;
      err_total   = '0;
      frame_total = '0;
      status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
          want = status_q.pop_front();
          cmp("byte_valid",   32'(byte_valid),   32'(want.byte_ok));
          cmp("byte_value",   32'(byte_value),   32'(want.value));
          cmp("byte_index",   32'(byte_index),   32'(want.index));
          cmp("frame_done",   32'(frame_done),   32'(want.done));
          cmp("frame_length", 32'(frame_length), 32'(want.length));
          cmp("frame_error",  32'(frame_error),  32'(want.err));
          cmp("errors_seen",  errors_seen,       want.errs);
          cmp("frames_seen",  frames_seen,       want.frames);
          checked++;
        end
      end
      // a byte taken at the same edge as a write still sees the old limit
      if (in_valid && in_ready) status_q.push_back(slip_decode(rx_byte));
      if (cfg_wr_en) len_limit = cfg_wr_data;
    end
    queued <= status_q.size();
  end

endmodule

>>> sim/tb_slip_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_slip_frame_decoder_unit
// Drives SLIP byte streams into the decoder under several length limits,
// with random gaps and result stalls; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_slip_frame_decoder_unit;
  import slipd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic                byte_valid;
  logic [BYTE_W-1:0]   byte_value;
  logic [COUNT_W-1:0]  byte_index;
  logic                frame_done;
  logic [COUNT_W-1:0]  frame_length;
  logic                frame_error;
  logic [STAT_W-1:0]   errors_seen;
  logic [STAT_W-1:0]   frames_seen;

  int fail_count;
  int queued;
  int checked;
  int sent;
  int limit_writes;
  bit calm;   // no gaps and no stalls while set

  slip_frame_decoder_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_valid   (byte_valid),
    .byte_value   (byte_value),
    .byte_index   (byte_index),
    .frame_done   (frame_done),
    .frame_length (frame_length),
    .frame_error  (frame_error),
    .errors_seen  (errors_seen),
    .frames_seen  (frames_seen)
  );

  slip_frame_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_valid   (byte_valid),
    .byte_value   (byte_value),
    .byte_index   (byte_index),
    .frame_done   (frame_done),
    .frame_length (frame_length),
    .frame_error  (frame_error),
    .errors_seen  (errors_seen),
    .frames_seen  (frames_seen),
    .fail_count   (fail_count),
    .queued       (queued),
    .checked      (checked)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("tb_slip_frame_decoder_unit: done, errors");
    $finish;
  end

  // result side: random stall before taking each result
  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request, after a random gap; returns at the accepting edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // stop sending and wait for every result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (queued != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_writes++;
  endtask

  // payload byte with SLIP stuffing
  task automatic send_payload(input logic [BYTE_W-1:0] b);
    if (b == FEND) begin
      send_byte(FESC);
      send_byte(TFEND);
    end else if (b == FESC) begin
      send_byte(FESC);
      send_byte(TFESC);
    end else begin
      send_byte(b);
    end
  endtask

  // framed packet; sometimes a bad escape or a missing closing END
  task automatic send_frame(input int n);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] junk;
    int i;
    send_byte(FEND);
    for (i = 0; i < n; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? FEND : FESC;
      if ($urandom_range(0, 39) == 0) begin
        junk = BYTE_W'($urandom_range(0, 255));
        if (junk == TFEND || junk == TFESC) junk = FEND;
        send_byte(FESC);
        send_byte(junk);
      end else begin
        send_payload(b);
      end
    end
    if ($urandom_range(0, 11) != 0) send_byte(FEND);
  endtask

  // random traffic under one length limit
  task automatic random_phase(input logic [COUNT_W-1:0] limit, input int budget,
                              input bit do_write);
    int start;
    int lim;
    int n;
    lim = int'(limit);
    if (do_write) write_limit(limit);
    start = sent;
    while (sent - start < budget) begin
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: send_byte(BYTE_W'($urandom_range(0, 255)));
        1: send_frame(0);
        default: begin
          // mostly short frames, some right at the limit
          if (lim != 0 && lim <= 300 && $urandom_range(0, 11) == 0)
            n = lim - 1 + int'($urandom_range(0, 2));
          else
            n = int'($urandom_range(0, (lim < 40) ? lim + 2 : 40));
          send_frame(n);
        end
      endcase
    end
    calm = 1'b0;
    drain();
  endtask

  // stimulus and verdict
  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    rx_byte      = '0;
    calm         = 1'b0;
    sent         = 0;
    limit_writes = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: ignored bytes, empty frame, escapes, bad escapes
    send_byte(8'h55);
    send_byte(FEND);
    send_byte(FEND);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(FESC);
    send_byte(TFEND);
    send_byte(FESC);
    send_byte(TFESC);
    send_byte(TFEND);
    send_byte(FEND);
    send_byte(FESC);
    send_byte(FEND);
    send_byte(8'h7F);
    send_byte(FESC);
    send_byte(8'h41);
    send_byte(8'h33);
    send_byte(FEND);
    send_byte(FESC);
    send_byte(FEND);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(FEND);
    drain();
    // limit of two: third payload byte aborts, and so does an END at the limit
    write_limit(16'd2);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(FEND);
    send_byte(8'h9A);
    send_byte(8'hBC);
    send_byte(FEND);
    send_byte(8'h01);
    drain();

    random_phase(MAX_LENGTH_RESET, 200, 1'b1);
    random_phase(16'd17, 250, 1'b1);
    random_phase(16'd3, 200, 1'b1);
    random_phase(16'd1, 150, 1'b1);
    random_phase(16'd0, 40, 1'b1);
    random_phase(16'hFFFF, 200, 1'b1);
    random_phase(COUNT_W'($urandom_range(2, 64)), 250, 1'b1);
    repeat (4) @(negedge clk);

    $display("Sent %0d bytes under %0d limit settings; %0d results compared.",
             sent, limit_writes + 1, checked);
    if (queued != 0) $display("%0d results never arrived", queued);
    if (fail_count == 0 && queued == 0) begin
      $display("tb_slip_frame_decoder_unit: done, clean");
    end else begin
      $display("tb_slip_frame_decoder_unit: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/slipd_pkg.sv
hdl/slip_frame_decoder_unit.sv
hdl/slipd_checker.sv
sim/slip_frame_checker.sv
sim/tb_slip_frame_decoder_unit.sv
